>>> design/psfutgm_pkg.sv
// Shared constants for the console font Unicode map block: operation and
// result codes, register indexes, table marks and map geometry.
// No dependencies.
`default_nettype none

package psfutgm_pkg;

  // map geometry
  localparam int MAP_ENTRIES = 65536;
  localparam int MAP_AW      = $clog2(MAP_ENTRIES);

  // operation codes
  localparam logic [1:0] OP_TABLE   = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  // lookup result kinds
  localparam logic [1:0] KIND_DIRECT = 2'd0;
  localparam logic [1:0] KIND_QMARK  = 2'd1;
  localparam logic [1:0] KIND_BLANK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TABLE_FORMAT = 2'd0;
  localparam logic [1:0] CFG_HAS_TABLE    = 2'd1;
  localparam logic [1:0] CFG_GLYPH_COUNT  = 2'd2;

  // table marks and special values
  localparam logic [15:0] NONE_ENTRY = 16'hFFFF;
  localparam logic [15:0] UCS_END    = 16'hFFFF;
  localparam logic [15:0] UCS_COMB   = 16'hFFFE;
  localparam logic [7:0]  UTF_END    = 8'hFF;
  localparam logic [7:0]  UTF_COMB   = 8'hFE;
  localparam int          QMARK_CP   = 63;

  // configuration reset values
  localparam logic        FMT_RESET   = 1'b1;
  localparam logic        HAS_RESET   = 1'b1;
  localparam logic [16:0] COUNT_RESET = 17'd256;

endpackage

`default_nettype wire

>>> design/psf_unicode_table_glyph_map_core.sv
// Console font Unicode map: table parser, glyph map memory and lookup.
// Depends on psfutgm_pkg.
`default_nettype none

// Usage
//   Input channel: a word (in_operation, in_table_byte, in_last_byte,
//   in_codepoint) is taken at a rising edge with start high and busy low.
//   Operations: table byte, lookup, restart (clears map), no operation.
//   Result channel: exactly one result word per input word, shown for one
//   cycle with out_valid high; the receiver cannot stall it.
//   Config port: cfg_we / cfg_index / cfg_data, written at any edge with
//   cfg_we high; write only while no word is in flight.
// Timing
//   For every word the map is read at the accept edge (one synchronous read
//   of the entry plus a fixed read of the '?' entry); the execute cycle
//   that follows writes back a new entry if needed and registers the
//   result, so out_valid rises as that execute cycle ends, and busy holds
//   the block through it, and through the map sweep after a restart word.
// Reset / restart
//   After reset and after a restart word the map is swept to "none", one
//   entry per cycle, all MAP_ENTRIES (65536) entries, with busy high. A restart
//   word's result is shown while the sweep writes its first entry.
module psf_unicode_table_glyph_map_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_table_byte,
  input  wire logic        in_last_byte,
  input  wire logic [20:0] in_codepoint,
  // result channel
  output logic             out_valid,
  output logic [15:0]      out_glyph_index,
  output logic [1:0]       out_lookup_kind,
  output logic             out_map_written,
  output logic             out_table_done,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  localparam int AW = psfutgm_pkg::MAP_AW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  // configuration registers
  logic        table_format_r;
  logic        has_table_r;
  logic [16:0] glyph_count_r;

  // control
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // parser state
  logic [16:0] counter_r, counter_nxt;
  logic        skip_r, skip_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [7:0]  low_hold_r, low_hold_nxt;
  logic        low_valid_r, low_valid_nxt;

  // word in flight
  logic [1:0]    op_r;
  logic [AW-1:0] addr_r;
  logic          rec_r;
  logic [15:0]   wr_glyph_r;
  logic          lk_in_range_r;

  // map memory
  logic [15:0]   glyph_map [psfutgm_pkg::MAP_ENTRIES];
  logic [15:0]   rd_cp_r;
  logic [15:0]   rd_q_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;

  // outputs
  logic        out_valid_r;
  logic [15:0] out_glyph_r, out_glyph_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic        out_written_r;

  logic        accept;
  logic        rec;
  logic        rec_ok;
  logic [20:0] rec_cp;
  logic [15:0] unit;
  logic [20:0] acc_shift;
  logic [1:0]  rem_dec;
  logic [15:0] cp_v;
  logic [15:0] q_v;
  logic        new_entry;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign unit      = {in_table_byte, low_hold_r};
  assign acc_shift = {acc_r[14:0], in_table_byte[5:0]};
  assign rem_dec   = rem_r - 2'd1;

  // ---------------------------------------------------------------------------
  // Parser: runs at the accept edge, yields at most one codepoint to record
  // ---------------------------------------------------------------------------
  always_comb begin
    counter_nxt   = counter_r;
    skip_nxt      = skip_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    low_hold_nxt  = low_hold_r;
    low_valid_nxt = low_valid_r;
    rec           = 1'b0;
    rec_cp        = '0;
    rd_addr       = in_codepoint[AW-1:0];

    if (accept && in_operation == psfutgm_pkg::OP_TABLE) begin
      if (has_table_r && counter_r < glyph_count_r) begin
        if (!table_format_r) begin
          // PSF1: pair bytes into little-endian 16-bit units
          if (low_valid_r) begin
            low_valid_nxt = 1'b0;
            if (unit == psfutgm_pkg::UCS_END) begin
              skip_nxt    = 1'b0;
              counter_nxt = counter_r + 17'd1;
            end else if (!skip_r) begin
              if (unit == psfutgm_pkg::UCS_COMB) begin
                skip_nxt = 1'b1;
              end else begin
                rec    = 1'b1;
                rec_cp = {5'd0, unit};
              end
            end
          end else begin
            low_hold_nxt  = in_table_byte;
            low_valid_nxt = 1'b1;
          end
        end else begin
          // PSF2: UTF-8, continuation bytes taken unchecked
          if (rem_r != 2'd0) begin
            acc_nxt = acc_shift;
            rem_nxt = rem_dec;
            if (rem_dec == 2'd0) begin
              rec    = 1'b1;
              rec_cp = acc_shift;
            end
          end else if (in_table_byte == psfutgm_pkg::UTF_END) begin
            skip_nxt    = 1'b0;
            counter_nxt = counter_r + 17'd1;
          end else if (!skip_r) begin
            if (in_table_byte == psfutgm_pkg::UTF_COMB) begin
              skip_nxt = 1'b1;
            end else if (!in_table_byte[7]) begin
              rec    = 1'b1;
              rec_cp = {13'd0, in_table_byte};
            end else if (in_table_byte[7:5] == 3'b110) begin
              acc_nxt = {16'd0, in_table_byte[4:0]};
              rem_nxt = 2'd1;
            end else if (in_table_byte[7:4] == 4'b1110) begin
              acc_nxt = {17'd0, in_table_byte[3:0]};
              rem_nxt = 2'd2;
            end else if (in_table_byte[7:3] == 5'b11110) begin
              acc_nxt = {18'd0, in_table_byte[2:0]};
              rem_nxt = 2'd3;
            end
          end
        end
      end
      if (in_last_byte) begin
        skip_nxt      = 1'b0;
        rem_nxt       = 2'd0;
        acc_nxt       = '0;
        low_hold_nxt  = '0;
        low_valid_nxt = 1'b0;
      end
      rd_addr = rec_cp[AW-1:0];
    end

    if (accept && in_operation == psfutgm_pkg::OP_RESTART) begin
      counter_nxt   = '0;
      skip_nxt      = 1'b0;
      rem_nxt       = 2'd0;
      acc_nxt       = '0;
      low_hold_nxt  = '0;
      low_valid_nxt = 1'b0;
    end
  end

  // out-of-range codepoints and glyph 0xFFFF or above never get an entry
  assign rec_ok = rec && (rec_cp < 21'(psfutgm_pkg::MAP_ENTRIES))
                  && (counter_r < {1'b0, psfutgm_pkg::NONE_ENTRY});

  // ---------------------------------------------------------------------------
  // Map memory: read at accept, write-back in EXEC, sweep in CLEAR
  // ---------------------------------------------------------------------------
  assign new_entry = rec_r && (rd_cp_r == psfutgm_pkg::NONE_ENTRY);
  assign mem_we    = (state_r == ST_CLEAR) || (state_r == ST_EXEC && new_entry);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : addr_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? psfutgm_pkg::NONE_ENTRY : wr_glyph_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_map[mem_waddr] <= mem_wdata;
    end
    rd_cp_r <= glyph_map[rd_addr];
    rd_q_r  <= glyph_map[AW'(psfutgm_pkg::QMARK_CP)];
  end

  // ---------------------------------------------------------------------------
  // Lookup resolution in EXEC: direct, then '?', then blank
  // ---------------------------------------------------------------------------
  always_comb begin
    if (!lk_in_range_r) begin
      cp_v = psfutgm_pkg::NONE_ENTRY;
    end else if (has_table_r) begin
      cp_v = rd_cp_r;
    end else if (17'(addr_r) < glyph_count_r) begin
      cp_v = 16'(addr_r);
    end else begin
      cp_v = psfutgm_pkg::NONE_ENTRY;
    end

    if (has_table_r) begin
      q_v = rd_q_r;
    end else if (17'(psfutgm_pkg::QMARK_CP) < glyph_count_r) begin
      q_v = 16'(psfutgm_pkg::QMARK_CP);
    end else begin
      q_v = psfutgm_pkg::NONE_ENTRY;
    end

    out_glyph_nxt = counter_r[15:0];
    out_kind_nxt  = psfutgm_pkg::KIND_DIRECT;
    if (op_r == psfutgm_pkg::OP_LOOKUP) begin
      if (cp_v != psfutgm_pkg::NONE_ENTRY) begin
        out_glyph_nxt = cp_v;
      end else if (q_v != psfutgm_pkg::NONE_ENTRY) begin
        out_glyph_nxt = q_v;
        out_kind_nxt  = psfutgm_pkg::KIND_QMARK;
      end else begin
        out_glyph_nxt = '0;
        out_kind_nxt  = psfutgm_pkg::KIND_BLANK;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == psfutgm_pkg::OP_RESTART) begin
          state_nxt    = ST_CLEAR;
          clr_addr_nxt = '0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(psfutgm_pkg::MAP_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      counter_r      <= '0;
      skip_r         <= 1'b0;
      rem_r          <= 2'd0;
      acc_r          <= '0;
      low_hold_r     <= '0;
      low_valid_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      table_format_r <= psfutgm_pkg::FMT_RESET;
      has_table_r    <= psfutgm_pkg::HAS_RESET;
      glyph_count_r  <= psfutgm_pkg::COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      counter_r   <= counter_nxt;
      skip_r      <= skip_nxt;
      rem_r       <= rem_nxt;
      acc_r       <= acc_nxt;
      low_hold_r  <= low_hold_nxt;
      low_valid_r <= low_valid_nxt;
      out_valid_r <= (state_r == ST_EXEC);
      if (cfg_we) begin
        case (cfg_index)
          psfutgm_pkg::CFG_TABLE_FORMAT: table_format_r <= cfg_data[0];
          psfutgm_pkg::CFG_HAS_TABLE:    has_table_r    <= cfg_data[0];
          psfutgm_pkg::CFG_GLYPH_COUNT:  glyph_count_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers: word in flight and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r          <= in_operation;
      addr_r        <= rd_addr;
      rec_r         <= rec_ok;
      wr_glyph_r    <= counter_r[15:0];
      lk_in_range_r <= (in_codepoint < 21'(psfutgm_pkg::MAP_ENTRIES));
    end
    if (state_r == ST_EXEC) begin
      out_glyph_r    <= out_glyph_nxt;
      out_kind_r     <= out_kind_nxt;
      out_written_r  <= new_entry;
      out_table_done <= (counter_r >= glyph_count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_glyph_index = out_glyph_r;
  assign out_lookup_kind = out_kind_r;
  assign out_map_written = out_written_r;

`ifndef SYNTH
  a_we_when_active: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_EXEC || state_r == ST_CLEAR))
    else $error("map written outside write-back or sweep");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted word did not enter execute");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_EXEC))
    else $error("result strobe without preceding execute cycle");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for psf_unicode_table_glyph_map_core: directed table and
// lookup words, then random font tables, checked word by word against a local map.
// Depends on psfutgm_pkg and the core RTL only.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psfutgm_pkg::*;

  // one result word as the core reports it
  typedef struct packed {
    logic [15:0] glyph;
    logic [1:0]  kind;
    logic        written;
    logic        done;
  } glyph_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [7:0]  in_table_byte;
  logic        in_last_byte;
  logic [20:0] in_codepoint;
  logic        out_valid;
  logic [15:0] out_glyph_index;
  logic [1:0]  out_lookup_kind;
  logic        out_map_written;
  logic        out_table_done;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  psf_unicode_table_glyph_map_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_table_byte   (in_table_byte),
    .in_last_byte    (in_last_byte),
    .in_codepoint    (in_codepoint),
    .out_valid       (out_valid),
    .out_glyph_index (out_glyph_index),
    .out_lookup_kind (out_lookup_kind),
    .out_map_written (out_map_written),
    .out_table_done  (out_table_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local copy of the glyph map and parser. Only codepoints that were actually
  // recorded have a key; a missing key means "no entry".
  // ---------------------------------------------------------------------------
  logic [15:0] codepoint_glyph [int];
  logic        fmt_reg;          // 0: UCS-2 LE pairs, 1: UTF-8
  logic        has_table_reg;
  logic [16:0] glyph_count_reg;
  logic [16:0] glyph_ctr;
  logic        skip_comb;        // inside a combining sequence
  logic [1:0]  utf8_left;        // continuation bytes still owed
  logic [20:0] utf8_acc;
  logic [7:0]  lo_hold;          // UCS-2 low byte waiting for its high byte
  logic        lo_pending;

  glyph_result_t glyph_results_due [$];   // results owed by accepted words
  logic [20:0]   seen_cps [$];            // recent codepoints, reused for hits
  int            idle_max;                // sender gap bound for the next words
  int            live_items;              // words sent so far
  bit            failed;
  int            errors_shown;

  function automatic void clear_parser();
    skip_comb  = 1'b0;
    utf8_left  = 2'd0;
    utf8_acc   = 21'd0;
    lo_hold    = 8'd0;
    lo_pending = 1'b0;
  endfunction

  function automatic void restart_map();
    codepoint_glyph.delete();
    glyph_ctr = 17'd0;
    clear_parser();
  endfunction

  // first sighting of a codepoint wins; glyph 0xFFFF and up can't be stored
  function automatic logic record_cp(logic [20:0] cp);
    if (cp >= MAP_ENTRIES || glyph_ctr >= 17'h0FFFF) return 1'b0;
    if (codepoint_glyph.exists(int'(cp))) return 1'b0;
    codepoint_glyph[int'(cp)] = glyph_ctr[15:0];
    return 1'b1;
  endfunction

  function automatic logic take_unit(logic [15:0] unit);
    if (unit == UCS_END) begin
      skip_comb = 1'b0;
      glyph_ctr = glyph_ctr + 17'd1;
      return 1'b0;
    end
    if (skip_comb) return 1'b0;
    if (unit == UCS_COMB) begin
      skip_comb = 1'b1;
      return 1'b0;
    end
    return record_cp({5'd0, unit});
  endfunction

  function automatic logic take_utf8(logic [7:0] b);
    // continuation bytes are taken as they come, marks included
    if (utf8_left != 2'd0) begin
      utf8_acc  = {utf8_acc[14:0], b[5:0]};
      utf8_left = utf8_left - 2'd1;
      return (utf8_left == 2'd0) ? record_cp(utf8_acc) : 1'b0;
    end
    if (b == UTF_END) begin
      skip_comb = 1'b0;
      glyph_ctr = glyph_ctr + 17'd1;
      return 1'b0;
    end
    if (skip_comb) return 1'b0;
    if (b == UTF_COMB) begin
      skip_comb = 1'b1;
      return 1'b0;
    end
    if (b[7] == 1'b0) return record_cp({13'd0, b});
    if (b[7:5] == 3'b110) begin
      utf8_acc  = {16'd0, b[4:0]};
      utf8_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      utf8_acc  = {17'd0, b[3:0]};
      utf8_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      utf8_acc  = {18'd0, b[2:0]};
      utf8_left = 2'd3;
    end
    // stray continuation or 0xF8..0xFD lead: dropped
    return 1'b0;
  endfunction

  function automatic logic [15:0] map_read(logic [20:0] cp);
    if (cp >= MAP_ENTRIES) return NONE_ENTRY;
    if (!has_table_reg) return ({4'd0, cp[16:0]} < {4'd0, glyph_count_reg}) ? cp[15:0] : NONE_ENTRY;
    return codepoint_glyph.exists(int'(cp)) ? codepoint_glyph[int'(cp)] : NONE_ENTRY;
  endfunction

  // advance the local copy by one word and return the result it owes
  function automatic glyph_result_t glyph_step(logic [1:0] op, logic [7:0] tbyte,
                                               logic lbyte, logic [20:0] cp);
    glyph_result_t r;
    logic [15:0]   hit;
    r = '0;
    case (op)
      OP_TABLE: begin
        if (has_table_reg && glyph_ctr < glyph_count_reg) begin
          if (fmt_reg == 1'b0) begin
            if (lo_pending) begin
              lo_pending = 1'b0;
              r.written  = take_unit({tbyte, lo_hold});
            end else begin
              lo_hold    = tbyte;
              lo_pending = 1'b1;
            end
          end else begin
            r.written = take_utf8(tbyte);
          end
        end
        if (lbyte) clear_parser();
      end
      OP_LOOKUP: begin
        hit = map_read(cp);
        if (hit != NONE_ENTRY) begin
          r.glyph = hit;
          r.kind  = KIND_DIRECT;
        end else begin
          hit = map_read(21'(QMARK_CP));
          if (hit != NONE_ENTRY) begin
            r.glyph = hit;
            r.kind  = KIND_QMARK;
          end else begin
            r.glyph = 16'd0;
            r.kind  = KIND_BLANK;
          end
        end
      end
      OP_RESTART: restart_map();
      default: ;
    endcase
    if (op != OP_LOOKUP) r.glyph = glyph_ctr[15:0];
    r.done = (glyph_ctr >= glyph_count_reg);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: out_valid and the fields are read as they stood before the
  // edge, i.e. the result of the oldest accepted word still owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    glyph_result_t got;
    glyph_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      got = '{out_glyph_index, out_lookup_kind, out_map_written, out_table_done};
      if (glyph_results_due.size() == 0) begin
        failed = 1'b1;
        if (errors_shown < 40) begin
          errors_shown++;
          $display("%0t: unexpected result word, expected none actual %h", $time, got);
        end
      end else begin
        want = glyph_results_due.pop_front();
        if (got !== want) begin
          failed = 1'b1;
          if (errors_shown < 40) begin
            errors_shown++;
            $display("%0t: mismatch expected glyph %h kind %0d written %0b done %0b",
                     $time, want.glyph, want.kind, want.written, want.done);
            $display("%0t:          actual   glyph %h kind %0d written %0b done %0b",
                     $time, got.glyph, got.kind, got.written, got.done);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Word driver. Called right after a rising edge; returns at the accept edge
  // with start still high, so a back-to-back word just overwrites the fields.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [1:0] op, input logic [7:0] tbyte,
                           input logic lbyte, input logic [20:0] cp);
    int gap;
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_operation  <= op;
    in_table_byte <= tbyte;
    in_last_byte  <= lbyte;
    in_codepoint  <= cp;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    live_items++;
    glyph_results_due.push_back(glyph_step(op, tbyte, lbyte, cp));
  endtask

  task automatic table_byte(input logic [7:0] b, input logic lbyte);
    send_word(OP_TABLE, b, lbyte, 21'($urandom));
  endtask

  task automatic lookup(input logic [20:0] cp);
    send_word(OP_LOOKUP, 8'($urandom), 1'($urandom), cp);
  endtask

  // end or combining mark in the current format
  task automatic send_mark(input logic [15:0] ucs, input logic [7:0] utf, input logic lbyte);
    if (!fmt_reg) begin
      table_byte(ucs[7:0], 1'b0);
      table_byte(ucs[15:8], lbyte);
    end else begin
      table_byte(utf, lbyte);
    end
  endtask

  // one codepoint, encoded for the current format
  task automatic send_cp(input logic [20:0] cp);
    if (!fmt_reg) begin
      table_byte(cp[7:0], 1'b0);
      table_byte(cp[15:8], 1'b0);
    end else if (cp < 21'h80) begin
      table_byte(cp[7:0], 1'b0);
    end else if (cp < 21'h800) begin
      table_byte({3'b110, cp[10:6]}, 1'b0);
      table_byte({2'b10, cp[5:0]}, 1'b0);
    end else if (cp < 21'h10000) begin
      table_byte({4'b1110, cp[15:12]}, 1'b0);
      table_byte({2'b10, cp[11:6]}, 1'b0);
      table_byte({2'b10, cp[5:0]}, 1'b0);
    end else begin
      table_byte({5'b11110, cp[20:18]}, 1'b0);
      table_byte({2'b10, cp[17:12]}, 1'b0);
      table_byte({2'b10, cp[11:6]}, 1'b0);
      table_byte({2'b10, cp[5:0]}, 1'b0);
    end
  endtask

  // codepoint for a table entry; repeats are common so first-seen logic gets hit
  function automatic logic [20:0] pick_cp();
    int          r;
    logic [20:0] cp;
    r = $urandom_range(0, 99);
    if (r < 3) cp = 21'(QMARK_CP);
    else if (r < 30) cp = 21'($urandom_range(0, 127));
    else if (r < 55 && seen_cps.size() != 0) cp = seen_cps[$urandom_range(0, seen_cps.size() - 1)];
    else if (r < 75) cp = 21'($urandom_range(128, 'h7FF));
    else if (r < 93) cp = 21'($urandom_range('h800, 'hFFFD));
    else cp = 21'($urandom_range('h10000, 'h1FFFFF));
    // UCS-2 can't carry large codepoints, and 0xFFFE/0xFFFF are marks there
    if (!fmt_reg && cp > 21'hFFFD) cp = 21'($urandom_range(0, 'hFFFD));
    seen_cps.push_back(cp);
    if (seen_cps.size() > 32) void'(seen_cps.pop_front());
    return cp;
  endfunction

  // start low, then wait for every owed result and for any map sweep to end
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (glyph_results_due.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_regs(input logic fmt, input logic has, input logic [16:0] count);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TABLE_FORMAT;
    cfg_data  <= {16'd0, fmt};
    @(posedge clk);
    cfg_index <= CFG_HAS_TABLE;
    cfg_data  <= {16'd0, has};
    @(posedge clk);
    cfg_index <= CFG_GLYPH_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    cfg_we          <= 1'b0;
    fmt_reg         = fmt;
    has_table_reg   = has;
    glyph_count_reg = count;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // reset defaults (UTF-8, table on, 256 glyphs), empty map: every lookup blank
  task automatic test_power_on();
    lookup(21'h41);
    lookup(21'h1FFFFF);
    send_word(OP_NOP, 8'hFF, 1'b1, 21'h1FFFFF);
  endtask

  // UTF-8 parsing: all sequence lengths, marks, strays, repeats, last byte
  task automatic test_utf8_table();
    table_byte(8'h41, 1'b0);                    // 'A' -> glyph 0
    table_byte(8'h3F, 1'b0);                    // '?' -> glyph 0
    table_byte(UTF_END, 1'b0);
    table_byte(8'hC3, 1'b0);                    // U+00E9, two bytes
    table_byte(8'hA9, 1'b0);
    table_byte(8'hE2, 1'b0);                    // U+20AC, three bytes
    table_byte(8'h82, 1'b0);
    table_byte(8'hAC, 1'b0);
    table_byte(8'hF0, 1'b0);                    // U+1F600, above the map
    table_byte(8'h9F, 1'b0);
    table_byte(8'h98, 1'b0);
    table_byte(8'h80, 1'b0);
    table_byte(8'h80, 1'b0);                    // stray continuation
    table_byte(8'hF8, 1'b0);                    // invalid lead
    table_byte(UTF_COMB, 1'b0);                 // combining: 'B' is skipped
    table_byte(8'h42, 1'b0);
    table_byte(UTF_END, 1'b0);
    table_byte(8'h41, 1'b0);                    // 'A' again: first one stays
    table_byte(8'hC3, 1'b0);                    // end mark as a continuation
    table_byte(UTF_END, 1'b0);
    table_byte(8'hE2, 1'b1);                    // partial sequence at last byte
    table_byte(8'h5A, 1'b0);
    lookup(21'h41);
    lookup(21'h20AC);
    lookup(21'h1F600);                          // falls back to '?'
    lookup(21'h42);
  endtask

  // UCS-2 pairs with the format switched mid-table
  task automatic test_ucs2_table();
    set_regs(1'b0, 1'b1, 17'd256);
    send_mark(16'h1234, 8'h00, 1'b0);
    send_mark(UCS_COMB, UTF_COMB, 1'b0);
    send_mark(16'h0042, 8'h00, 1'b0);
    send_mark(UCS_END, UTF_END, 1'b0);
    table_byte(8'h78, 1'b1);                    // lone low byte dropped
    send_mark(16'h0056, 8'h00, 1'b0);
    lookup(21'h1234);
    lookup(21'h0056);
  endtask

  // identity map below the glyph count, table bytes have no effect
  task automatic test_no_table();
    set_regs(1'b1, 1'b0, 17'd1);
    lookup(21'd0);
    lookup(21'd1);                              // '?' is out of range too: blank
    set_regs(1'b1, 1'b0, 17'd64);
    table_byte(8'h41, 1'b0);
    lookup(21'd63);
    lookup(21'd200);                            // '?' fallback to glyph 63
    lookup(21'hFFFF);
  endtask

  // counter already past a glyph count of 1: bytes ignored, map still answers
  task automatic test_table_finished();
    set_regs(1'b1, 1'b1, 17'd1);
    table_byte(8'h61, 1'b0);
    lookup(21'h41);
  endtask

  // restart, then walk the counter to 0xFFFF where nothing can be stored,
  // and on to the full 65536-glyph count
  task automatic test_glyph_ceiling();
    int saved_idle;
    saved_idle = idle_max;
    set_regs(1'b1, 1'b1, 17'h10000);
    send_word(OP_RESTART, 8'hFF, 1'b1, 21'h1FFFFF);
    lookup(21'h41);
    idle_max = 0;
    repeat (65535) table_byte(UTF_END, 1'b0);
    table_byte(8'h41, 1'b0);                    // glyph 0xFFFF: no entry
    table_byte(UTF_END, 1'b0);                  // count reached
    table_byte(8'h42, 1'b0);
    lookup(21'h41);
    idle_max = saved_idle;
  endtask

  // ---------------------------------------------------------------------------
  // Random tables: mostly well-formed glyph entries, mixed with lookups,
  // noise bytes, no-ops and sequences cut short by the last-byte flag.
  // ---------------------------------------------------------------------------
  task automatic test_random_tables(input logic fmt, input logic has,
                                    input logic [16:0] count, input bit fresh,
                                    input int amount);
    int          stop_at;
    int          pick;
    int          r;
    logic [20:0] cp;
    set_regs(fmt, has, count);
    if (fresh) send_word(OP_RESTART, 8'($urandom), 1'($urandom), 21'($urandom));
    stop_at = live_items + amount;
    while (live_items < stop_at) begin
      if ($urandom_range(0, 31) == 0) begin
        r        = $urandom_range(0, 2);
        idle_max = (r == 0) ? 0 : ((r == 1) ? 4 : 16);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // one glyph entry: a few codepoints, maybe a combining run, end mark
        repeat ($urandom_range(1, 3)) send_cp(pick_cp());
        if ($urandom_range(0, 5) == 0) begin
          send_mark(UCS_COMB, UTF_COMB, 1'b0);
          send_cp(pick_cp());
        end
        send_mark(UCS_END, UTF_END, 1'b0);
      end else if (pick < 75) begin
        r = $urandom_range(0, 9);
        if (r < 4 && seen_cps.size() != 0) cp = seen_cps[$urandom_range(0, seen_cps.size() - 1)];
        else if (r < 5) cp = 21'(QMARK_CP);
        else if (r < 7) cp = 21'($urandom_range(0, 255));
        else if (r < 8) cp = 21'($urandom_range(0, 'hFFFF));
        else cp = 21'($urandom_range(0, 'h1FFFFF));
        lookup(cp);
      end else if (pick < 85) begin
        table_byte(8'($urandom), ($urandom_range(0, 9) == 0));
      end else if (pick < 90) begin
        send_word(OP_NOP, 8'($urandom), 1'($urandom), 21'($urandom));
      end else if (pick < 95) begin
        // sequence cut short by the last byte; parser must start clean after
        if (fmt_reg) begin
          table_byte(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
          table_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b1);
        end else begin
          table_byte(8'($urandom), 1'b1);
        end
        send_cp(pick_cp());
      end else begin
        // combining run closed by the last byte instead of an end mark
        send_mark(UCS_COMB, UTF_COMB, 1'b1);
        send_cp(pick_cp());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    failed       = 1'b0;
    errors_shown = 0;
    live_items   = 0;
    idle_max     = 16;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_operation  <= OP_NOP;
    in_table_byte <= 8'd0;
    in_last_byte  <= 1'b0;
    in_codepoint  <= 21'd0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_TABLE_FORMAT;
    cfg_data      <= 17'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    fmt_reg         = FMT_RESET;
    has_table_reg   = HAS_RESET;
    glyph_count_reg = COUNT_RESET;
    restart_map();

    test_power_on();
    test_utf8_table();
    test_ucs2_table();
    test_no_table();
    test_table_finished();
    test_glyph_ceiling();
    test_random_tables(1'b1, 1'b1, 17'h10000, 1'b1, 350);
    test_random_tables(1'b0, 1'b1, 17'($urandom_range(8, 48)), 1'b1, 300);
    test_random_tables(1'b1, 1'b1, 17'd1, 1'b1, 150);
    test_random_tables(1'b0, 1'b0, 17'($urandom_range(1, 65536)), 1'b0, 250);
    test_random_tables(1'b1, 1'b1, 17'($urandom_range(64, 400)), 1'b1, 300);
    // format flips without a restart: both parsers carry on as they stand
    test_random_tables(1'b0, 1'b1, 17'h10000, 1'b0, 300);

    wait_quiet();
    repeat (4) @(posedge clk);
    if (!failed) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // watchdog: six map sweeps plus the ceiling walk is well under this
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> psf_unicode_table_glyph_map_core.f
design/psfutgm_pkg.sv
design/psf_unicode_table_glyph_map_core.sv
tb/tb_top.sv
